/* design/cosim_pkg.sv */
// ----------------------------------------------------------------------------
// Cosine similarity package
// Shared widths, codes, the queue entry type and the back-end state types.
// ----------------------------------------------------------------------------
package cosim_pkg;

    localparam int MAX_DIM        = 1024;
    localparam int VALUE_WIDTH    = 16;
    localparam int ADDR_WIDTH     = $clog2(MAX_DIM);
    localparam int LEN_WIDTH      = 11;
    localparam int ROW_WIDTH      = 16;
    localparam int SUM_WIDTH      = 48;
    localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH     = QPTR_WIDTH + 1;

    // Input commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ROW  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_ROW_COUNT     = 1'b1;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] dot;
        logic [SUM_WIDTH-1:0] query_energy;
        logic [SUM_WIDTH-1:0] row_energy;
        logic [ROW_WIDTH-1:0] row_index;
        logic                 last_row;
    } row_sums_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DRAIN,
        BK_CHECK,
        BK_SQUARE,
        BK_FINISH
    } back_state_t;

    typedef enum logic [1:0] {
        PH_NORM,
        PH_MAG,
        PH_TRIAL
    } mul_phase_t;

endpackage

/* design/cosim_front.sv */
// ----------------------------------------------------------------------------
// Cosine similarity front end
// Takes items, stores query elements, and accumulates the three sums of each
// row through a read, multiply and accumulate pipeline.
// ----------------------------------------------------------------------------
module cosim_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [cosim_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic signed [cosim_pkg::VALUE_WIDTH-1:0] element_value,
    input  logic [cosim_pkg::QCNT_WIDTH-1:0]     queue_count,
    output logic                                 push,
    output cosim_pkg::row_sums_t                 push_data
);
    import cosim_pkg::*;

    logic [LEN_WIDTH-1:0]  vector_length_reg;
    logic [ROW_WIDTH-1:0]  row_count_reg;
    logic [LEN_WIDTH-1:0]  eff_len;
    logic [ROW_WIDTH-1:0]  eff_rows;
    logic [ADDR_WIDTH-1:0] load_pos_reg, load_pos_next, load_sel;
    logic [ADDR_WIDTH-1:0] row_pos_reg, row_pos_next, row_sel;
    logic                  load_wrap, row_wrap, accept;

    logic [VALUE_WIDTH-1:0] query_mem [MAX_DIM];
    logic signed [VALUE_WIDTH-1:0] q_rd_reg;

    logic                          s1_valid_reg, s1_last_reg;
    logic signed [VALUE_WIDTH-1:0] s1_b_reg;
    logic                          s2_valid_reg, s2_last_reg;
    logic signed [PROD_WIDTH-1:0]  qb_reg, qq_reg, bb_reg;

    logic [SUM_WIDTH-1:0] dot_reg, qe_reg, re_reg;
    logic [SUM_WIDTH-1:0] dot_next, qe_next, re_next;
    logic [ROW_WIDTH-1:0] row_counter_reg;
    logic                 is_last;
    logic [QCNT_WIDTH-1:0] pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= LEN_WIDTH'(MAX_DIM);
            row_count_reg     <= ROW_WIDTH'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VECTOR_LENGTH: vector_length_reg <= cfg_data[LEN_WIDTH-1:0];
                REG_ROW_COUNT:     row_count_reg     <= cfg_data[ROW_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (vector_length_reg == '0)
            eff_len = LEN_WIDTH'(1);
        else if (vector_length_reg > LEN_WIDTH'(MAX_DIM))
            eff_len = LEN_WIDTH'(MAX_DIM);
        else
            eff_len = vector_length_reg;
        eff_rows = (row_count_reg == '0) ? ROW_WIDTH'(1) : row_count_reg;
    end

    // A position left beyond a shortened length is clamped to the last element.
    assign load_sel  = ({1'b0, load_pos_reg} < eff_len) ? load_pos_reg
                                                       : ADDR_WIDTH'(eff_len - 1'b1);
    assign row_sel   = ({1'b0, row_pos_reg} < eff_len) ? row_pos_reg
                                                      : ADDR_WIDTH'(eff_len - 1'b1);
    assign load_wrap = ({1'b0, load_sel} + 1'b1) >= eff_len;
    assign row_wrap  = ({1'b0, row_sel} + 1'b1) >= eff_len;

    assign pending  = QCNT_WIDTH'(s1_valid_reg && s1_last_reg)
                    + QCNT_WIDTH'(s2_valid_reg && s2_last_reg);
    assign in_ready = (queue_count + pending) < QCNT_WIDTH'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        load_pos_next = load_pos_reg;
        row_pos_next  = row_pos_reg;
        if (accept && command == CMD_LOAD)
            load_pos_next = load_wrap ? '0 : load_sel + 1'b1;
        if (accept && command == CMD_ROW)
            row_pos_next = row_wrap ? '0 : row_sel + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_LOAD)
            query_mem[load_sel] <= element_value;
        if (accept && command == CMD_ROW)
            q_rd_reg <= query_mem[row_sel];
    end

    always_ff @(posedge clk)
    begin
        s1_b_reg <= element_value;
        qb_reg   <= q_rd_reg * s1_b_reg;
        qq_reg   <= q_rd_reg * q_rd_reg;
        bb_reg   <= s1_b_reg * s1_b_reg;
    end

    assign dot_next = dot_reg + {{(SUM_WIDTH-PROD_WIDTH){qb_reg[PROD_WIDTH-1]}}, qb_reg};
    assign qe_next  = qe_reg  + {{(SUM_WIDTH-PROD_WIDTH){qq_reg[PROD_WIDTH-1]}}, qq_reg};
    assign re_next  = re_reg  + {{(SUM_WIDTH-PROD_WIDTH){bb_reg[PROD_WIDTH-1]}}, bb_reg};
    assign is_last  = ({1'b0, row_counter_reg} + 1'b1) >= {1'b0, eff_rows};

    assign push                   = s2_valid_reg && s2_last_reg;
    assign push_data.dot          = dot_next;
    assign push_data.query_energy = qe_next;
    assign push_data.row_energy   = re_next;
    assign push_data.row_index    = row_counter_reg;
    assign push_data.last_row     = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg    <= '0;
            row_pos_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s2_last_reg     <= 1'b0;
            dot_reg         <= '0;
            qe_reg          <= '0;
            re_reg          <= '0;
            row_counter_reg <= '0;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            row_pos_reg  <= row_pos_next;
            s1_valid_reg <= accept && command == CMD_ROW;
            s1_last_reg  <= row_wrap;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    dot_reg         <= '0;
                    qe_reg          <= '0;
                    re_reg          <= '0;
                    row_counter_reg <= is_last ? '0 : row_counter_reg + 1'b1;
                end
                else
                begin
                    dot_reg <= dot_next;
                    qe_reg  <= qe_next;
                    re_reg  <= re_next;
                end
            end
        end
    end

endmodule

/* design/cosim_queue.sv */
// ----------------------------------------------------------------------------
// Cosine similarity row queue
// Short queue of finished row sums between the front end and the scorer.
// ----------------------------------------------------------------------------
module cosim_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  cosim_pkg::row_sums_t             push_data,
    input  logic                             pop,
    output logic                             head_valid,
    output cosim_pkg::row_sums_t             head_data,
    output logic [cosim_pkg::QCNT_WIDTH-1:0] count
);
    import cosim_pkg::*;

    row_sums_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] count_reg;

    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
        end
    end

endmodule

/* design/cosim_back.sv */
// ----------------------------------------------------------------------------
// Cosine similarity scorer
// Turns one row's sums into a rounded Q1.15 score with a shared 32x32
// multiplier: norm product, squared magnitude, then a bitwise search.
// ----------------------------------------------------------------------------
module cosim_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_valid,
    input  cosim_pkg::row_sums_t                 head_data,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [cosim_pkg::VALUE_WIDTH-1:0] score,
    output logic                                 zero_denominator,
    output logic [cosim_pkg::ROW_WIDTH-1:0]      row_index,
    output logic                                 last_row
);
    import cosim_pkg::*;

    back_state_t state_reg, state_next;
    mul_phase_t  phase_reg;
    logic [2:0]  cnt_reg;
    logic [3:0]  bit_reg;
    logic        pp_valid_reg;

    logic [SUM_WIDTH-1:0]   mag_reg;
    logic                   neg_reg, zero_reg, last_reg;
    logic [ROW_WIDTH-1:0]   row_reg;
    logic [95:0]            opa_reg, p_reg;
    logic [63:0]            opb_reg, pp_reg;
    logic [1:0]             sh_reg;
    logic [127:0]           acc_reg, l_reg;
    logic [15:0]            k_reg, trial;
    logic [16:0]            m_wide;
    logic [31:0]            m_sq;
    logic [31:0]            a_chunk, b_chunk;
    logic                   trial_ok, out_free, issue, clear_acc;
    logic [VALUE_WIDTH-1:0] score_val;

    logic                          out_valid_reg, zero_out_reg, last_out_reg;
    logic signed [VALUE_WIDTH-1:0] score_reg;
    logic [ROW_WIDTH-1:0]          row_out_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign trial    = k_reg | (16'h0001 << bit_reg);
    assign m_wide   = {trial, 1'b0} - 1'b1;
    assign m_sq     = m_wide[15:0] * m_wide[15:0];
    assign trial_ok = acc_reg <= l_reg;

    always_comb
    begin
        unique case (cnt_reg[2:1])
            2'd0:    a_chunk = opa_reg[31:0];
            2'd1:    a_chunk = opa_reg[63:32];
            default: a_chunk = opa_reg[95:64];
        endcase
        b_chunk = cnt_reg[0] ? opb_reg[63:32] : opb_reg[31:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (head_valid) state_next = BK_MUL;
            BK_MUL:    if (cnt_reg == 3'd5) state_next = BK_DRAIN;
            BK_DRAIN:  state_next = BK_CHECK;
            BK_CHECK:
            begin
                unique case (phase_reg)
                    PH_NORM:  state_next = (acc_reg <= 128'd2) ? BK_FINISH : BK_MUL;
                    PH_MAG:   state_next = BK_SQUARE;
                    default:
                    begin
                        if ((trial_ok && bit_reg == 4'd15) || bit_reg == 4'd0)
                            state_next = BK_FINISH;
                        else
                            state_next = BK_SQUARE;
                    end
                endcase
            end
            BK_SQUARE: state_next = BK_MUL;
            BK_FINISH: if (out_free) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop       = 1'b0;
        issue     = 1'b0;
        clear_acc = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop       = head_valid;
                clear_acc = 1'b1;
            end
            BK_MUL:    issue     = 1'b1;
            BK_CHECK:  clear_acc = 1'b1;
            BK_SQUARE: clear_acc = 1'b1;
            default:   ;
        endcase
    end

    always_comb
    begin
        if (zero_reg)
            score_val = '0;
        else if (neg_reg)
            score_val = 16'd0 - k_reg;
        else if (k_reg[15])
            score_val = 16'h7FFF;
        else
            score_val = k_reg;
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= a_chunk * b_chunk;
        sh_reg <= cnt_reg[2:1] + {1'b0, cnt_reg[0]};
        if (clear_acc)
            acc_reg <= '0;
        else if (pp_valid_reg)
            acc_reg <= acc_reg + ({64'd0, pp_reg} << {sh_reg, 5'd0});

        unique case (state_reg)
            BK_IDLE:
            begin
                neg_reg  <= head_data.dot[SUM_WIDTH-1];
                mag_reg  <= head_data.dot[SUM_WIDTH-1] ? SUM_WIDTH'(0) - head_data.dot
                                                       : head_data.dot;
                opa_reg  <= {48'd0, head_data.query_energy};
                opb_reg  <= {16'd0, head_data.row_energy};
                row_reg  <= head_data.row_index;
                last_reg <= head_data.last_row;
                zero_reg <= 1'b0;
            end
            BK_CHECK:
            begin
                unique case (phase_reg)
                    PH_NORM:
                    begin
                        p_reg    <= acc_reg[95:0];
                        zero_reg <= acc_reg <= 128'd2;
                        opa_reg  <= {48'd0, mag_reg};
                        opb_reg  <= {16'd0, mag_reg};
                    end
                    PH_MAG:
                    begin
                        l_reg <= acc_reg << 32;
                        k_reg <= '0;
                    end
                    default:
                    begin
                        if (trial_ok)
                            k_reg <= trial;
                    end
                endcase
            end
            BK_SQUARE:
            begin
                opa_reg <= p_reg;
                opb_reg <= {32'd0, m_sq};
            end
            default: ;
        endcase

        if (state_reg == BK_FINISH && out_free)
        begin
            score_reg    <= score_val;
            zero_out_reg <= zero_reg;
            row_out_reg  <= row_reg;
            last_out_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            phase_reg     <= PH_NORM;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            pp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pp_valid_reg <= issue;
            cnt_reg      <= issue ? cnt_reg + 1'b1 : '0;
            if (state_reg == BK_IDLE)
                phase_reg <= PH_NORM;
            else if (state_reg == BK_CHECK)
            begin
                unique case (phase_reg)
                    PH_NORM: phase_reg <= PH_MAG;
                    PH_MAG:
                    begin
                        phase_reg <= PH_TRIAL;
                        bit_reg   <= 4'd15;
                    end
                    default: bit_reg <= bit_reg - 1'b1;
                endcase
            end
            if (state_reg == BK_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign score            = score_reg;
    assign zero_denominator = zero_out_reg;
    assign row_index        = row_out_reg;
    assign last_row         = last_out_reg;

endmodule

/* design/cosine_similarity_batch.sv */
// ----------------------------------------------------------------------------
// Cosine similarity batch scorer
// Scores streamed rows against a stored query vector by cosine similarity.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    command, element_value
//   out      out_valid/out_ready  score, zero_denominator, row_index, last_row
//   cfg      cfg_write            cfg_index, cfg_data
//
// The front end takes one item per cycle while the four-entry row queue has
// room. Each finished row then occupies the scorer: every product takes six
// 32x32 partial products plus a drain and a check state, for the norm product,
// the squared magnitude and up to 16 trial squares. Reset leaves the query
// store unwritten, the length at 1024 and the row count at 1. A stalled output
// holds the scorer; the queue absorbs rows.
// ----------------------------------------------------------------------------
module cosine_similarity_batch (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [cosim_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic signed [cosim_pkg::VALUE_WIDTH-1:0] element_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [cosim_pkg::VALUE_WIDTH-1:0] score,
    output logic                                 zero_denominator,
    output logic [cosim_pkg::ROW_WIDTH-1:0]      row_index,
    output logic                                 last_row
);
    import cosim_pkg::*;

    logic                  push, pop, head_valid;
    row_sums_t             push_data, head_data;
    logic [QCNT_WIDTH-1:0] queue_count;

    cosim_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .element_value (element_value),
        .queue_count   (queue_count),
        .push          (push),
        .push_data     (push_data)
    );

    cosim_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (queue_count)
    );

    cosim_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_data        (head_data),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .score            (score),
        .zero_denominator (zero_denominator),
        .row_index        (row_index),
        .last_row         (last_row)
    );

endmodule
